FILE: hw/rtl/cdve_pkg.sv
// Shared types, constants and register addresses of the drift velocity estimator.
`default_nettype none
package cdve_pkg;
   localparam int AXES_DEFAULT = 3;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int MAX_AXES = 3;
   localparam int ADDR_BITS = 5;

   localparam logic [ADDR_BITS-1:0] ADDR_MODE     = 5'd0;
   localparam logic [ADDR_BITS-1:0] ADDR_VEL_CAP  = 5'd4;
   localparam logic [ADDR_BITS-1:0] ADDR_INT_CAP  = 5'd8;
   localparam logic [ADDR_BITS-1:0] ADDR_TARGET_X = 5'd12;
   localparam logic [ADDR_BITS-1:0] ADDR_TARGET_Y = 5'd16;
   localparam logic [ADDR_BITS-1:0] ADDR_TARGET_Z = 5'd20;

   localparam logic MODE_DIFF = 1'b0;
   localparam logic MODE_PID  = 1'b1;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        step_time;
   } req_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] sum_x;
      logic signed [31:0] sum_y;
      logic signed [31:0] sum_z;
      logic               primed;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        priming;
      logic        pid;
      logic [30:0] vel_cap;
      logic [30:0] int_cap;
   } lane_ctl_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] vel;
      logic signed [31:0] sum;
   } lane_res_type;
endpackage
`default_nettype wire

FILE: hw/rtl/cdve_lane.sv
// One axis lane: error, integral update and a bit-serial restoring divider.
`default_nettype none
module cdve_lane #(
   parameter int FRAC_BITS = 16
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire cdve_pkg::lane_ctl_type  ctl,
   input  wire logic signed [31:0]      pos,
   input  wire logic signed [31:0]      target,
   input  wire logic [30:0]             dt,
   output cdve_pkg::lane_res_type       res
);
   import cdve_pkg::*;

   localparam int NUM_BITS = 33 + FRAC_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic signed [31:0]         last_pos_ff, last_pos_in;
   logic signed [31:0]         last_err_ff, last_err_in;
   logic signed [31:0]         sum_ff, sum_in;
   logic signed [31:0]         err_ff, err_in;
   logic signed [63:0]         prod_ff, prod_in;
   logic [NUM_BITS-1:0]        quo_ff, quo_in;
   logic [31:0]                rem_ff, rem_in;
   logic                       neg_ff, neg_in;
   logic                       pid_ff, pid_in;
   logic [30:0]                dt_ff, dt_in;
   logic [30:0]                vcap_ff, vcap_in;
   logic [30:0]                icap_ff, icap_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic signed [31:0]         vel_ff, vel_in;

   logic signed [32:0]         err_wide;
   logic signed [31:0]         err_sat;
   logic signed [32:0]         diff;
   logic [32:0]                diff_mag;
   logic signed [63:0]         inc;
   logic signed [63:0]         acc;
   logic [32:0]                rem_sh;
   logic [NUM_BITS:0]          q_mag;
   logic signed [NUM_BITS+1:0] q_s;

   always_comb begin
      err_wide = 33'(pos) - 33'(target);
      if (err_wide > 33'sh0_7FFF_FFFF) begin
         err_sat = 32'sh7FFF_FFFF;
      end else if (err_wide < -33'sh0_8000_0000) begin
         err_sat = 32'sh8000_0000;
      end else begin
         err_sat = err_wide[31:0];
      end
      if (ctl.pid) begin
         diff = 33'(err_sat) - 33'(last_err_ff);
      end else begin
         diff = 33'(pos) - 33'(last_pos_ff);
      end
      diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
      inc = prod_ff >>> FRAC_BITS;
      if (prod_ff[63] && (prod_ff[FRAC_BITS-1:0] != '0)) begin
         inc = inc + 64'sd1;
      end
      acc = 64'(sum_ff) + inc;
      rem_sh = {rem_ff, quo_ff[NUM_BITS-1]};
      q_mag = {1'b0, quo_ff};
      q_s = neg_ff ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
   end

   always_comb begin
      state_in = state_ff;
      last_pos_in = last_pos_ff;
      last_err_in = last_err_ff;
      sum_in = sum_ff;
      err_in = err_ff;
      prod_in = prod_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      neg_in = neg_ff;
      pid_in = pid_ff;
      dt_in = dt_ff;
      vcap_in = vcap_ff;
      icap_in = icap_ff;
      cnt_in = cnt_ff;
      vel_in = vel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               last_pos_in = pos;
               dt_in = dt;
               vcap_in = ctl.vel_cap;
               icap_in = ctl.int_cap;
               pid_in = ctl.pid;
               if (ctl.priming) begin
                  sum_in = '0;
                  last_err_in = err_sat;
                  vel_in = '0;
                  state_in = ST_DONE;
               end else begin
                  if (ctl.pid) begin
                     last_err_in = err_sat;
                  end
                  err_in = err_sat;
                  neg_in = diff[32];
                  quo_in = NUM_BITS'({diff_mag, {FRAC_BITS{1'b0}}});
                  rem_in = '0;
                  cnt_in = CNT_BITS'(NUM_BITS);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in = 64'(err_ff) * $signed({33'd0, dt_ff});
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == NUM_BITS[CNT_BITS-1:0] && pid_ff) begin
               if (acc > 64'($signed({1'b0, icap_ff}))) begin
                  sum_in = $signed({1'b0, icap_ff});
               end else if (acc < -64'($signed({1'b0, icap_ff}))) begin
                  sum_in = -$signed({1'b0, icap_ff});
               end else begin
                  sum_in = acc[31:0];
               end
            end
            if (rem_sh >= {2'b0, dt_ff}) begin
               rem_in = 32'(rem_sh - {2'b0, dt_ff});
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[31:0];
               quo_in = {quo_ff[NUM_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_BITS'(1)) begin
               state_in = ST_DONE;
               vel_in = '1;
            end
         end
         ST_DONE: begin
            if (vel_ff == '1 && state_ff == ST_DONE && cnt_ff == '0) begin
               if (q_s > (NUM_BITS+2)'($signed({1'b0, vcap_ff}))) begin
                  vel_in = $signed({1'b0, vcap_ff});
               end else if (q_s < -(NUM_BITS+2)'($signed({1'b0, vcap_ff}))) begin
                  vel_in = -$signed({1'b0, vcap_ff});
               end else begin
                  vel_in = q_s[31:0];
               end
               cnt_in = CNT_BITS'(1);
            end else begin
               state_in = ST_IDLE;
               cnt_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_pos_ff <= '0;
         last_err_ff <= '0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_pos_ff <= last_pos_in;
         last_err_ff <= last_err_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
      err_ff <= err_in;
      prod_ff <= prod_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
      pid_ff <= pid_in;
      dt_ff <= dt_in;
      vcap_ff <= vcap_in;
      icap_ff <= icap_in;
      vel_ff <= vel_in;
   end

   assign res.done = (state_ff == ST_DONE) && (cnt_ff != '0 || vel_ff != '1);
   assign res.vel = vel_ff;
   assign res.sum = sum_ff;
endmodule
`default_nettype wire

FILE: hw/rtl/clamped_drift_velocity_estimator.sv
// Top level of the drift velocity estimator: registers, lanes and result merge.
// A request passes the lane states ST_MUL, ST_DIV and ST_DONE before its result is
// registered; a priming request goes from ST_IDLE straight to ST_DONE.
// A new request is taken once the previous result has left the output register.
// Reset is synchronous: registers return to their reset values, the lane state
// clears and the next request is the priming step.
`default_nettype none
module clamped_drift_velocity_estimator #(
   parameter int AXES = cdve_pkg::AXES_DEFAULT,
   parameter int FRAC_BITS = cdve_pkg::FRAC_BITS_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire cdve_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output cdve_pkg::rsp_type                    rsp_data,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire logic [cdve_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [31:0]                     csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready
);
   import cdve_pkg::*;

   logic               mode_ff;
   logic [30:0]        vcap_ff;
   logic [30:0]        icap_ff;
   logic signed [31:0] tgt_ff [MAX_AXES];
   logic               first_ff;
   logic               busy_ff;
   logic               primed_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   logic               wr;
   logic               accept;
   lane_ctl_type       ctl;
   lane_res_type       res [MAX_AXES];
   logic signed [31:0] pos [MAX_AXES];

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign accept = req_valid && !req_stall;
   assign req_stall = busy_ff || rsp_valid_ff;
   assign pos[0] = req_data.pos_x;
   assign pos[1] = req_data.pos_y;
   assign pos[2] = req_data.pos_z;

   always_comb begin
      case (csr_paddr)
         ADDR_MODE:     csr_prdata = {31'd0, mode_ff};
         ADDR_VEL_CAP:  csr_prdata = {1'b0, vcap_ff};
         ADDR_INT_CAP:  csr_prdata = {1'b0, icap_ff};
         ADDR_TARGET_X: csr_prdata = tgt_ff[0];
         ADDR_TARGET_Y: csr_prdata = tgt_ff[1];
         ADDR_TARGET_Z: csr_prdata = tgt_ff[2];
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      ctl.start = accept;
      ctl.priming = first_ff;
      ctl.pid = (mode_ff == MODE_PID);
      ctl.vel_cap = vcap_ff;
      ctl.int_cap = icap_ff;
   end

   for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
      if (a < AXES) begin : g_on
         cdve_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .clock(clock), .reset(reset), .ctl(ctl), .pos(pos[a]),
            .target(tgt_ff[a]), .dt(req_data.step_time), .res(res[a]));
      end else begin : g_off
         assign res[a] = '{done: 1'b1, vel: '0, sum: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_DIFF;
         vcap_ff <= 31'(1 << FRAC_BITS);
         icap_ff <= 31'(5 << FRAC_BITS);
         for (int i = 0; i < MAX_AXES; i++) tgt_ff[i] <= '0;
         first_ff <= 1'b1;
         busy_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         primed_ff <= 1'b0;
      end else begin
         if (wr) begin
            case (csr_paddr)
               ADDR_MODE:     mode_ff <= csr_pwdata[0];
               ADDR_VEL_CAP:  vcap_ff <= csr_pwdata[30:0];
               ADDR_INT_CAP:  icap_ff <= csr_pwdata[30:0];
               ADDR_TARGET_X: tgt_ff[0] <= csr_pwdata;
               ADDR_TARGET_Y: tgt_ff[1] <= csr_pwdata;
               ADDR_TARGET_Z: tgt_ff[2] <= csr_pwdata;
               default: ;
            endcase
         end
         if (accept) begin
            busy_ff <= 1'b1;
            primed_ff <= first_ff;
            first_ff <= 1'b0;
         end else if (busy_ff && res[0].done && res[1].done && res[2].done) begin
            busy_ff <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (busy_ff && !rsp_valid_ff) begin
         rsp_ff.vel_x <= res[0].vel;
         rsp_ff.vel_y <= res[1].vel;
         rsp_ff.vel_z <= res[2].vel;
         rsp_ff.sum_x <= res[0].sum;
         rsp_ff.sum_y <= res[1].sum;
         rsp_ff.sum_z <= res[2].sum;
         rsp_ff.primed <= primed_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

FILE: tb/tb_clamped_drift_velocity_estimator.sv
// Testbench of the drift velocity estimator: directed and random requests against a predictor.
`default_nettype none
module tb_clamped_drift_velocity_estimator;
   timeunit 1ns;
   timeprecision 1ps;
   import cdve_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   clamped_drift_velocity_estimator u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   logic cur_mode;
   longint cur_vel_cap, cur_int_cap;
   longint cur_target [3];
   longint prev_pos [3];
   longint prev_err [3];
   longint err_sum [3];
   bit awaiting_first;

   rsp_type expected_rsps [$];
   int mismatch_count = 0;
   int request_count = 0;
   int rsp_count = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit stall_enable = 1'b0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint limit_velocity(longint diff, longint dt);
      longint q;
      if (dt == 0) q = diff > 0 ? cur_vel_cap : (diff < 0 ? -cur_vel_cap : 0);
      else q = (diff * 65536) / dt;
      return clamp(q, -cur_vel_cap, cur_vel_cap);
   endfunction

   function automatic rsp_type predict_velocity(req_type r);
      rsp_type o;
      longint dt, pos, prv, err, inc;
      longint vel [3];
      longint sum [3];
      dt = longint'(r.step_time);
      for (int a = 0; a < 3; a++) begin
         vel[a] = 0;
         sum[a] = 0;
         pos = a == 0 ? longint'(r.pos_x) : a == 1 ? longint'(r.pos_y) : longint'(r.pos_z);
         prv = prev_pos[a];
         err = clamp(pos - cur_target[a], -64'sd2147483648, 64'sd2147483647);
         prev_pos[a] = pos;
         if (awaiting_first) begin
            err_sum[a] = 0;
            prev_err[a] = err;
         end else if (cur_mode == MODE_PID) begin
            inc = (err * dt) / 65536;
            err_sum[a] = clamp(err_sum[a] + inc, -cur_int_cap, cur_int_cap);
            vel[a] = limit_velocity(err - prev_err[a], dt);
            prev_err[a] = err;
         end else begin
            vel[a] = limit_velocity(pos - prv, dt);
         end
         sum[a] = awaiting_first ? 0 : err_sum[a];
      end
      o.vel_x = vel[0][31:0];
      o.vel_y = vel[1][31:0];
      o.vel_z = vel[2][31:0];
      o.sum_x = sum[0][31:0];
      o.sum_y = sum[1][31:0];
      o.sum_z = sum[2][31:0];
      o.primed = awaiting_first;
      awaiting_first = 1'b0;
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d", rsp_count, field, got, want);
      mismatch_count++;
   endtask

   task automatic reset_predictor();
      cur_mode = MODE_DIFF;
      cur_vel_cap = 65536;
      cur_int_cap = 327680;
      for (int a = 0; a < 3; a++) begin
         cur_target[a] = 0;
         prev_pos[a] = 0;
         prev_err[a] = 0;
         err_sum[a] = 0;
      end
      awaiting_first = 1'b1;
   endtask

   task automatic write_reg(logic [ADDR_BITS-1:0] addr, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (addr)
         ADDR_MODE: cur_mode = value[0];
         ADDR_VEL_CAP: cur_vel_cap = longint'(value[30:0]);
         ADDR_INT_CAP: cur_int_cap = longint'(value[30:0]);
         ADDR_TARGET_X: cur_target[0] = longint'(signed'(value));
         ADDR_TARGET_Y: cur_target[1] = longint'(signed'(value));
         ADDR_TARGET_Z: cur_target[2] = longint'(signed'(value));
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure(logic m, logic [30:0] vc, logic [30:0] ic,
                            logic [31:0] tx, logic [31:0] ty, logic [31:0] tz);
      wait_drained();
      write_reg(ADDR_MODE, {31'd0, m});
      write_reg(ADDR_VEL_CAP, {1'b0, vc});
      write_reg(ADDR_INT_CAP, {1'b0, ic});
      write_reg(ADDR_TARGET_X, tx);
      write_reg(ADDR_TARGET_Y, ty);
      write_reg(ADDR_TARGET_Z, tz);
   endtask

   task automatic send_request(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      expected_rsps.push_back(predict_velocity(r));
      request_count++;
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clock);
   endtask

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 400000) - 200000;
         3: return $urandom_range(0, 20000) - 10000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [30:0] random_step();
      case ($urandom_range(0, 4))
         0: return 31'd1;
         1: return 31'h7fff_ffff;
         2: return 31'($urandom_range(1, 131072));
         default: return 31'($urandom_range(1, 32'h7fff_ffff));
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.pos_x = random_coord();
      r.pos_y = random_coord();
      r.pos_z = random_coord();
      r.step_time = random_step();
      return r;
   endfunction

   task automatic test_directed_extremes();
      req_type r;
      r = '{32'h0001_0000, 32'hffff_0000, 32'h0, 31'h0001_0000};
      send_request(r);
      r = '{32'h7fff_ffff, 32'h8000_0000, 32'h0002_0000, 31'd1};
      send_request(r);
      r = '{32'h8000_0000, 32'h7fff_ffff, 32'h0002_0000, 31'h7fff_ffff};
      send_request(r);
      r = '{32'h0000_8000, 32'hffff_8000, 32'h0002_0001, 31'h0000_4000};
      send_request(r);
      req_valid <= 1'b0;
      configure(MODE_PID, 31'h7fff_ffff, 31'd0, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
      r = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 31'd1};
      send_request(r);
      r = '{32'h8000_0000, 32'h7fff_ffff, 32'h1234, 31'h7fff_ffff};
      send_request(r);
      req_valid <= 1'b0;
      configure(MODE_PID, 31'd0, 31'h7fff_ffff, 32'h0001_0000, 32'hfffe_0000, 32'h0003_0000);
      for (int i = 0; i < 8; i++) send_request(random_request());
      req_valid <= 1'b0;
      configure(MODE_DIFF, 31'h0001_0000, 31'h0005_0000, 32'h0, 32'h0, 32'h0);
      for (int i = 0; i < 6; i++) send_request(random_request());
      req_valid <= 1'b0;
   endtask

   task automatic test_random_traffic(int count);
      int burst;
      stall_enable = 1'b1;
      while (count > 0) begin
         if (count % 250 == 0) begin
            req_valid <= 1'b0;
            configure(1'($urandom_range(0, 1)),
                      $urandom_range(0, 5) == 0 ? 31'h7fff_ffff
                      : 31'($urandom_range(0, 600000)),
                      $urandom_range(0, 5) == 0 ? 31'h7fff_ffff
                      : 31'($urandom_range(0, 2000000)),
                      random_coord(), random_coord(), random_coord());
         end
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && count > 0; i++) begin
            send_request(random_request());
            count--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
      req_valid <= 1'b0;
      stall_enable = 1'b0;
   endtask

   task automatic test_backpressure();
      hold_rsp = 1'b1;
      for (int i = 0; i < 6; i++) send_request(random_request());
      req_valid <= 1'b0;
      wait (!hold_rsp);
   endtask

   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (stall_enable) begin
            rsp_stall <= ($urandom_range(0, 3) == 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.vel_x !== want.vel_x) report_mismatch("vel_x", rsp_data.vel_x, want.vel_x);
            if (rsp_data.vel_y !== want.vel_y) report_mismatch("vel_y", rsp_data.vel_y, want.vel_y);
            if (rsp_data.vel_z !== want.vel_z) report_mismatch("vel_z", rsp_data.vel_z, want.vel_z);
            if (rsp_data.sum_x !== want.sum_x) report_mismatch("sum_x", rsp_data.sum_x, want.sum_x);
            if (rsp_data.sum_y !== want.sum_y) report_mismatch("sum_y", rsp_data.sum_y, want.sum_y);
            if (rsp_data.sum_z !== want.sum_z) report_mismatch("sum_z", rsp_data.sum_z, want.sum_z);
            if (rsp_data.primed !== want.primed)
               report_mismatch("primed", rsp_data.primed, want.primed);
         end
         rsp_count++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d idle cycles", idle_cycles);
         $display("clamped_drift_velocity_estimator regression: fail");
         $finish;
      end
   end

   initial begin
      reset_predictor();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_backpressure();
      test_random_traffic(2000);
      wait_drained();
      if (expected_rsps.size() != 0) report_mismatch("results left over", expected_rsps.size(), 0);
      $display("Sent %0d requests and checked %0d results in both modes,", request_count, rsp_count);
      $display("across extreme caps, targets and time steps with random gaps and stalls.");
      if (mismatch_count == 0) $display("clamped_drift_velocity_estimator regression: pass");
      else $display("clamped_drift_velocity_estimator regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
